/* rtl/core/tcpo_pkg.sv */
// Shared types, option codes and the helper function of the TCP option parser.
package tcpo_pkg;

	// option kinds with special handling
	localparam logic [7:0] KIND_END    = 8'd0;
	localparam logic [7:0] KIND_NOP    = 8'd1;
	localparam logic [7:0] KIND_MSS    = 8'd2;
	localparam logic [7:0] KIND_WSCALE = 8'd3;
	localparam logic [7:0] KIND_SACKP  = 8'd4;
	localparam logic [7:0] KIND_SACK   = 8'd5;
	localparam logic [7:0] KIND_TS     = 8'd8;
	localparam logic [7:0] KIND_UTO    = 8'd28;

	// record kinds on the result channel
	localparam logic [1:0] REC_WHOLE  = 2'd0;
	localparam logic [1:0] REC_BLOCK  = 2'd1;
	localparam logic [1:0] REC_STATUS = 2'd2;

	// command opcodes from front to back
	typedef logic [1:0] op_t;
	localparam op_t OP_SHIFT  = 2'd0;
	localparam op_t OP_WHOLE  = 2'd1;
	localparam op_t OP_BLOCK  = 2'd2;
	localparam op_t OP_STATUS = 2'd3;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       hi_word;
		logic [7:0] kind;
		logic [7:0] length;
		logic       fin;
		logic       bad;
	} cmd_t;

	function automatic logic length_ok(input logic [7:0] kind, input logic [7:0] len);
		logic ok;
		ok = 1'b1;
		if (len < 8'd2) begin
			ok = 1'b0;
		end else begin
			case (kind)
				KIND_MSS:    ok = (len == 8'd4);
				KIND_WSCALE: ok = (len == 8'd3);
				KIND_SACKP:  ok = (len == 8'd2);
				KIND_UTO:    ok = (len == 8'd2);
				KIND_TS:     ok = (len == 8'd10);
				KIND_SACK:   ok = (len[2:0] == 3'd2);
				default:     ok = 1'b1;
			endcase
		end
		return ok;
	endfunction

endpackage

/* rtl/core/tcpo_in_if.sv */
// Byte channel carrying the raw options area.
interface tcpo_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] option_byte;
	logic       last_byte;

	modport source(output valid, option_byte, last_byte, input ready);
	modport sink(input valid, option_byte, last_byte, output ready);
endinterface

/* rtl/core/tcpo_rec_if.sv */
// Record channel carrying parsed option records.
interface tcpo_rec_if;
	logic        valid;
	logic        ready;
	logic [1:0]  record_kind;
	logic [7:0]  option_type;
	logic [7:0]  option_length;
	logic [31:0] value_a;
	logic [31:0] value_b;
	logic        final_res;
	logic        malformed;

	modport source(output valid, record_kind, option_type, option_length, value_a,
		value_b, final_res, malformed, input ready);
	modport sink(input valid, record_kind, option_type, option_length, value_a,
		value_b, final_res, malformed, output ready);
endinterface

/* rtl/core/tcp_option_parser_unit.sv */
// Top level of the TCP option parser: front end, command queue and back end.
//
//   channel  | dir | transaction contents
//   ---------+-----+------------------------------------------------------------
//   in_ch    | in  | option_byte, last_byte
//   rec_ch   | out | record_kind, option_type, option_length, value_a, value_b,
//            |     | final_res, malformed
//
// One byte is taken per cycle while the queue has room; the record a byte completes is
// queued when the byte is accepted and enters the output register when rec_ch allows.
// Reset returns the parser to expecting a kind byte and empties queue and output.
// in_ch stalls only when the command queue is full; value bytes and records each take
// a queue slot, so a record held on rec_ch stalls in_ch once the queue behind it fills.
module tcp_option_parser_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	tcpo_in_if.sink     in_ch,
	tcpo_rec_if.source  rec_ch
);

	logic           f_valid, f_ready;
	tcpo_pkg::cmd_t f_cmd;
	logic           b_valid, b_ready;
	tcpo_pkg::cmd_t b_cmd;

	tcpo_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cmd_valid (f_valid),
		.cmd       (f_cmd),
		.cmd_ready (f_ready)
	);

	tcpo_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_cmd   (f_cmd),
		.push_ready (f_ready),
		.pop_valid  (b_valid),
		.pop_cmd    (b_cmd),
		.pop_ready  (b_ready)
	);

	tcpo_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_valid),
		.cmd       (b_cmd),
		.cmd_ready (b_ready),
		.rec_ch    (rec_ch)
	);

endmodule

/* rtl/core/tcpo_front.sv */
// Front end: tracks the kind/length/value framing and classifies each byte.
module tcpo_front (
	input  logic             clk,
	input  logic             arst_n,
	tcpo_in_if.sink          in_ch,
	output logic             cmd_valid,
	output tcpo_pkg::cmd_t   cmd,
	input  logic             cmd_ready
);

	localparam logic [1:0] PH_KIND  = 2'd0;
	localparam logic [1:0] PH_LEN   = 2'd1;
	localparam logic [1:0] PH_VALUE = 2'd2;
	localparam logic [1:0] PH_SKIP  = 2'd3;

	logic [1:0] phase_q, phase_d;
	logic [7:0] kind_q, kind_d;
	logic [7:0] len_q, len_d;
	logic [7:0] left_q, left_d;
	logic [2:0] idx_q, idx_d;
	logic       accept;
	logic       push;
	logic [7:0] b;
	logic       last;
	logic [7:0] left_n;

	assign in_ch.ready = cmd_ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign b           = in_ch.option_byte;
	assign last        = in_ch.last_byte;
	assign left_n      = left_q - 8'd1;
	assign cmd_valid   = accept && push;

	always_comb begin
		phase_d     = phase_q;
		kind_d      = kind_q;
		len_d       = len_q;
		left_d      = left_q;
		idx_d       = idx_q;
		push        = 1'b0;
		cmd.op      = tcpo_pkg::OP_STATUS;
		cmd.data    = b;
		cmd.hi_word = idx_q[2];
		cmd.kind    = kind_q;
		cmd.length  = len_q;
		cmd.fin     = 1'b0;
		cmd.bad     = 1'b0;
		case (phase_q)
			PH_KIND: begin
				cmd.kind   = b;
				cmd.length = 8'd0;
				if (b == tcpo_pkg::KIND_END) begin
					push    = 1'b1;
					cmd.fin = 1'b1;
					phase_d = last ? PH_KIND : PH_SKIP;
				end else if (b == tcpo_pkg::KIND_NOP) begin
					push    = last;
					cmd.fin = 1'b1;
				end else begin
					kind_d  = b;
					len_d   = 8'd0;
					left_d  = 8'd0;
					idx_d   = 3'd0;
					push    = last;
					cmd.fin = 1'b1;
					cmd.bad = 1'b1;
					phase_d = last ? PH_KIND : PH_LEN;
				end
			end
			PH_LEN: begin
				len_d      = b;
				cmd.length = b;
				if (!tcpo_pkg::length_ok(kind_q, b)) begin
					push    = 1'b1;
					cmd.fin = 1'b1;
					cmd.bad = 1'b1;
					phase_d = last ? PH_KIND : PH_SKIP;
				end else if (b == 8'd2) begin
					push    = 1'b1;
					cmd.op  = tcpo_pkg::OP_WHOLE;
					cmd.fin = last;
					phase_d = PH_KIND;
				end else if (last) begin
					push    = 1'b1;
					cmd.fin = 1'b1;
					cmd.bad = 1'b1;
					phase_d = PH_KIND;
				end else begin
					left_d  = b - 8'd2;
					phase_d = PH_VALUE;
				end
			end
			PH_VALUE: begin
				push   = 1'b1;
				left_d = left_n;
				idx_d  = idx_q + 3'd1;
				if (left_n != 8'd0 && last) begin
					cmd.fin = 1'b1;
					cmd.bad = 1'b1;
					phase_d = PH_KIND;
				end else if (kind_q == tcpo_pkg::KIND_SACK && idx_q == 3'd7) begin
					cmd.op  = tcpo_pkg::OP_BLOCK;
					cmd.fin = (left_n == 8'd0) && last;
					if (left_n == 8'd0) begin
						phase_d = PH_KIND;
					end
				end else if (left_n == 8'd0) begin
					cmd.op  = tcpo_pkg::OP_WHOLE;
					cmd.fin = last;
					phase_d = PH_KIND;
				end else begin
					cmd.op = tcpo_pkg::OP_SHIFT;
				end
			end
			default: begin
				// drop bytes until the area ends
				if (last) begin
					phase_d = PH_KIND;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KIND;
			kind_q  <= 8'd0;
			len_q   <= 8'd0;
			left_q  <= 8'd0;
			idx_q   <= 3'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			len_q   <= len_d;
			left_q  <= left_d;
			idx_q   <= idx_d;
		end
	end

	a_value_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_VALUE |-> left_q != 8'd0)
		else $error("value phase with no bytes owed");

	a_last_resets_phase: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> phase_q == PH_KIND)
		else $error("parser not back at kind byte after area end");

	a_last_pushes_final: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd.bad |-> cmd.fin)
		else $error("malformed command not marked final");

endmodule

/* rtl/core/tcpo_queue.sv */
// Short command queue between the front and back ends.
module tcpo_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  tcpo_pkg::cmd_t push_cmd,
	output logic           push_ready,
	output logic           pop_valid,
	output tcpo_pkg::cmd_t pop_cmd,
	input  logic           pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tcpo_pkg::cmd_t     slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count over depth");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> wr_q == rd_q)
		else $error("empty queue with split pointers");

	a_full_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'(DEPTH) |-> wr_q == rd_q)
		else $error("full queue with split pointers");

endmodule

/* rtl/core/tcpo_back.sv */
// Back end: assembles value words and drives the registered record output.
module tcpo_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  tcpo_pkg::cmd_t cmd,
	output logic           cmd_ready,
	tcpo_rec_if.source     rec_ch
);

	logic [31:0] first_q, second_q;
	logic [31:0] first_n, second_n;
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  type_q, len_q;
	logic [31:0] va_q, vb_q;
	logic        fin_q, bad_q;
	logic        take;
	logic [1:0]  rk_d;
	logic [31:0] va_d, vb_d;

	assign cmd_ready = !out_valid_q || rec_ch.ready;
	assign take      = cmd_valid && cmd_ready;

	assign first_n  = cmd.hi_word ? first_q : {first_q[23:0], cmd.data};
	assign second_n = cmd.hi_word ? {second_q[23:0], cmd.data} : second_q;

	always_comb begin
		rk_d = tcpo_pkg::REC_STATUS;
		va_d = 32'd0;
		vb_d = 32'd0;
		case (cmd.op)
			tcpo_pkg::OP_WHOLE: begin
				rk_d = tcpo_pkg::REC_WHOLE;
				if (cmd.kind == tcpo_pkg::KIND_MSS || cmd.kind == tcpo_pkg::KIND_WSCALE) begin
					va_d = first_n;
				end else if (cmd.kind == tcpo_pkg::KIND_TS) begin
					va_d = first_n;
					vb_d = second_n;
				end
			end
			tcpo_pkg::OP_BLOCK: begin
				rk_d = tcpo_pkg::REC_BLOCK;
				va_d = first_n;
				vb_d = second_n;
			end
			default: begin
				rk_d = tcpo_pkg::REC_STATUS;
			end
		endcase
	end

	// payload: words collect value bytes and clear after every record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= 32'd0;
			second_q <= 32'd0;
		end else if (take) begin
			if (cmd.op == tcpo_pkg::OP_SHIFT) begin
				first_q  <= first_n;
				second_q <= second_n;
			end else begin
				first_q  <= 32'd0;
				second_q <= 32'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && cmd.op != tcpo_pkg::OP_SHIFT) begin
			out_valid_q <= 1'b1;
		end else if (rec_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && cmd.op != tcpo_pkg::OP_SHIFT) begin
			kind_q <= rk_d;
			type_q <= cmd.kind;
			len_q  <= cmd.length;
			va_q   <= va_d;
			vb_q   <= vb_d;
			fin_q  <= cmd.fin;
			bad_q  <= cmd.bad;
		end
	end

	assign rec_ch.valid         = out_valid_q;
	assign rec_ch.record_kind   = kind_q;
	assign rec_ch.option_type   = type_q;
	assign rec_ch.option_length = len_q;
	assign rec_ch.value_a       = va_q;
	assign rec_ch.value_b       = vb_q;
	assign rec_ch.final_res     = fin_q;
	assign rec_ch.malformed     = bad_q;

	a_bad_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && bad_q |-> kind_q == tcpo_pkg::REC_STATUS && fin_q)
		else $error("malformed record not a final status record");

	a_block_is_sack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == tcpo_pkg::REC_BLOCK |-> type_q == tcpo_pkg::KIND_SACK)
		else $error("block record for a kind other than SACK");

	a_words_clear: assert property (@(posedge clk) disable iff (!arst_n)
		take && cmd.op != tcpo_pkg::OP_SHIFT |=> first_q == 32'd0 && second_q == 32'd0)
		else $error("value words not cleared after a record");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Testbench of tcp_option_parser_unit: directed and random option areas checked by a predictor.
module tb;

	localparam int ITEM_TARGET = 1900;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 20;

	localparam logic [1:0] ST_KIND  = 2'd0;
	localparam logic [1:0] ST_LEN   = 2'd1;
	localparam logic [1:0] ST_VALUE = 2'd2;
	localparam logic [1:0] ST_SKIP  = 2'd3;

	typedef enum logic [1:0] {IDLE_MIX_A, IDLE_MIX_B, IDLE_NONE} idle_mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       hold;
		idle_mode_t mode;
	} opt_byte_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  typ;
		logic [7:0]  len;
		logic [31:0] va;
		logic [31:0] vb;
		logic        fin;
		logic        bad;
	} opt_record_t;

	logic clk;
	logic arst_n;

	tcpo_in_if  in_ch();
	tcpo_rec_if rec_ch();

	tcp_option_parser_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.rec_ch(rec_ch)
	);

	opt_byte_t   byte_stream[$];
	opt_record_t records_due[$];
	idle_mode_t  gen_mode;
	idle_mode_t  rx_mode;
	logic        hold_next;
	int          fail_count;
	int          bytes_taken;
	int          records_seen;
	int          areas_built;
	int          cycle_count;

	// predictor state
	logic [1:0]   pstate;
	logic [7:0]   cur_kind;
	logic [7:0]   cur_len;
	logic [7:0]   bytes_left;
	logic [2:0]   blk_idx;
	logic [31:0]  word_a;
	logic [31:0]  word_b;

	function automatic logic option_len_legal(input logic [7:0] kind, input logic [7:0] len);
		if (len < 8'd2)
			return 1'b0;
		case (kind)
			tcpo_pkg::KIND_MSS:    return len == 8'd4;
			tcpo_pkg::KIND_WSCALE: return len == 8'd3;
			tcpo_pkg::KIND_SACKP:  return len == 8'd2;
			tcpo_pkg::KIND_UTO:    return len == 8'd2;
			tcpo_pkg::KIND_TS:     return len == 8'd10;
			tcpo_pkg::KIND_SACK:   return ((len - 8'd2) & 8'h07) == 8'h00;
			default:               return 1'b1;
		endcase
	endfunction

	function automatic void push_record(input logic [1:0] rk, input logic [7:0] ty, len,
		input logic [31:0] va, vb, input logic fin, bad);
		records_due.push_back(opt_record_t'{rk, ty, len, va, vb, fin, bad});
	endfunction

	function automatic void parse_byte(input logic [7:0] b, input logic last);
		logic [2:0]  idx;
		logic [31:0] va;
		logic [31:0] vb;
		case (pstate)
			ST_KIND: begin
				if (b == tcpo_pkg::KIND_END) begin
					push_record(tcpo_pkg::REC_STATUS, tcpo_pkg::KIND_END, 8'd0, 32'd0, 32'd0,
						1'b1, 1'b0);
					pstate = last ? ST_KIND : ST_SKIP;
				end else if (b == tcpo_pkg::KIND_NOP) begin
					if (last)
						push_record(tcpo_pkg::REC_STATUS, tcpo_pkg::KIND_NOP, 8'd0, 32'd0,
							32'd0, 1'b1, 1'b0);
				end else begin
					cur_kind = b;
					cur_len = 8'd0;
					bytes_left = 8'd0;
					blk_idx = 3'd0;
					word_a = 32'd0;
					word_b = 32'd0;
					if (last)
						push_record(tcpo_pkg::REC_STATUS, b, 8'd0, 32'd0, 32'd0, 1'b1, 1'b1);
					else
						pstate = ST_LEN;
				end
			end
			ST_LEN: begin
				cur_len = b;
				if (!option_len_legal(cur_kind, b)) begin
					push_record(tcpo_pkg::REC_STATUS, cur_kind, b, 32'd0, 32'd0, 1'b1, 1'b1);
					pstate = last ? ST_KIND : ST_SKIP;
				end else if (b == 8'd2) begin
					push_record(tcpo_pkg::REC_WHOLE, cur_kind, 8'd2, 32'd0, 32'd0, last, 1'b0);
					pstate = ST_KIND;
				end else if (last) begin
					push_record(tcpo_pkg::REC_STATUS, cur_kind, b, 32'd0, 32'd0, 1'b1, 1'b1);
					pstate = ST_KIND;
				end else begin
					bytes_left = b - 8'd2;
					pstate = ST_VALUE;
				end
			end
			ST_VALUE: begin
				idx = blk_idx;
				bytes_left = bytes_left - 8'd1;
				if (idx < 3'd4)
					word_a = {word_a[23:0], b};
				else
					word_b = {word_b[23:0], b};
				blk_idx = idx + 3'd1;
				if (bytes_left != 8'd0 && last) begin
					// area ran out while value bytes were still owed
					push_record(tcpo_pkg::REC_STATUS, cur_kind, cur_len, 32'd0, 32'd0,
						1'b1, 1'b1);
					pstate = ST_KIND;
				end else if (cur_kind == tcpo_pkg::KIND_SACK && idx == 3'd7) begin
					push_record(tcpo_pkg::REC_BLOCK, tcpo_pkg::KIND_SACK, cur_len, word_a,
						word_b, (bytes_left == 8'd0) && last, 1'b0);
					word_a = 32'd0;
					word_b = 32'd0;
					if (bytes_left == 8'd0)
						pstate = ST_KIND;
				end else if (bytes_left == 8'd0) begin
					va = 32'd0;
					vb = 32'd0;
					if (cur_kind == tcpo_pkg::KIND_MSS || cur_kind == tcpo_pkg::KIND_WSCALE) begin
						va = word_a;
					end else if (cur_kind == tcpo_pkg::KIND_TS) begin
						va = word_a;
						vb = word_b;
					end
					push_record(tcpo_pkg::REC_WHOLE, cur_kind, cur_len, va, vb, last, 1'b0);
					pstate = ST_KIND;
				end
			end
			default: begin
				if (last)
					pstate = ST_KIND;
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want, got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
		end
	endfunction

	function automatic void push_area(input logic [7:0] area[$]);
		foreach (area[i]) begin
			byte_stream.push_back(opt_byte_t'{area[i], i == area.size() - 1, hold_next, gen_mode});
			hold_next = 1'b0;
		end
		areas_built++;
	endfunction

	function automatic void append_option(ref logic [7:0] area[$]);
		logic [7:0] k;
		logic [7:0] len;
		k = tcpo_pkg::KIND_NOP;
		len = 8'd0;
		case ($urandom_range(0, 9))
			1: begin k = tcpo_pkg::KIND_MSS; len = 8'd4; end
			2: begin k = tcpo_pkg::KIND_WSCALE; len = 8'd3; end
			3: begin k = tcpo_pkg::KIND_SACKP; len = 8'd2; end
			4: begin k = tcpo_pkg::KIND_TS; len = 8'd10; end
			5, 6: begin
				k = tcpo_pkg::KIND_SACK;
				len = 8'(2 + 8 * (($urandom_range(0, 19) == 0) ? $urandom_range(5, 31)
					: $urandom_range(0, 4)));
			end
			7: begin k = tcpo_pkg::KIND_UTO; len = 8'd2; end
			8, 9: begin
				do
					k = 8'($urandom_range(6, 255));
				while (k == tcpo_pkg::KIND_TS || k == tcpo_pkg::KIND_UTO);
				len = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(13, 255))
					: 8'($urandom_range(2, 12));
			end
			default: ;
		endcase
		area.push_back(k);
		if (k != tcpo_pkg::KIND_NOP) begin
			area.push_back(len);
			repeat (int'(len) - 2)
				area.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	function automatic void append_bad_length(ref logic [7:0] area[$]);
		logic [7:0] k;
		logic [7:0] len;
		case ($urandom_range(0, 6))
			0: k = tcpo_pkg::KIND_MSS;
			1: k = tcpo_pkg::KIND_WSCALE;
			2: k = tcpo_pkg::KIND_SACKP;
			3: k = tcpo_pkg::KIND_SACK;
			4: k = tcpo_pkg::KIND_TS;
			5: k = tcpo_pkg::KIND_UTO;
			default: k = 8'($urandom_range(6, 255));
		endcase
		// favor near misses of the required length
		do
			len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, 12));
		while (option_len_legal(k, len));
		area.push_back(k);
		area.push_back(len);
	endfunction

	task automatic build_random_area();
		logic [7:0] area[$];
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 88)
			repeat ($urandom_range(1, 4))
				append_option(area);
		if (pick < 62) begin
			if ($urandom_range(0, 3) == 0) begin
				area.push_back(tcpo_pkg::KIND_END);
				repeat ($urandom_range(0, 3))
					area.push_back(8'($urandom_range(0, 255)));
			end
		end else if (pick < 74) begin
			// cut the area short, mostly inside an option
			area = area[0:$urandom_range(0, area.size() - 1)];
		end else if (pick < 88) begin
			append_bad_length(area);
			repeat ($urandom_range(0, 4))
				area.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 10))
				area.push_back(8'($urandom_range(0, 255)));
		end
		push_area(area);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		gen_mode = IDLE_MIX_A;
		hold_next = 1'b0;

		push_area('{tcpo_pkg::KIND_END});
		push_area('{tcpo_pkg::KIND_NOP});
		push_area('{8'hFF});
		push_area('{tcpo_pkg::KIND_NOP, tcpo_pkg::KIND_WSCALE, 8'd3, 8'h0E,
			tcpo_pkg::KIND_SACKP, 8'd2, tcpo_pkg::KIND_END, 8'hAA});
		push_area('{tcpo_pkg::KIND_MSS, 8'd1, 8'h55});
		push_area('{tcpo_pkg::KIND_SACK, 8'd2, tcpo_pkg::KIND_UTO, 8'd2});
		push_area('{tcpo_pkg::KIND_TS, 8'd10, 8'h01, 8'h02, 8'h03});
		push_area('{tcpo_pkg::KIND_MSS, 8'd4, 8'hFF, 8'hFF});

		// each idle pattern starts after the parser has drained
		hold_next = 1'b1;
		while (byte_stream.size() < ITEM_TARGET / 3)
			build_random_area();
		gen_mode = IDLE_MIX_B;
		hold_next = 1'b1;
		while (byte_stream.size() < 2 * ITEM_TARGET / 3)
			build_random_area();
		gen_mode = IDLE_NONE;
		hold_next = 1'b1;
		while (byte_stream.size() < ITEM_TARGET)
			build_random_area();

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (byte_stream.size() != 0 || in_ch.valid || records_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Fed %0d option bytes in %0d areas under three idle patterns,", bytes_taken,
			areas_built);
		$display("checked %0d parsed records, %0d errors.", records_seen, fail_count);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// byte driver, predicting on each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.option_byte <= 8'd0;
			in_ch.last_byte <= 1'b0;
			rx_mode <= IDLE_MIX_A;
			pstate = ST_KIND;
			cur_kind = 8'd0;
			cur_len = 8'd0;
			bytes_left = 8'd0;
			blk_idx = 3'd0;
			word_a = 32'd0;
			word_b = 32'd0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				parse_byte(in_ch.option_byte, in_ch.last_byte);
				bytes_taken++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (byte_stream.size() != 0
						&& !(byte_stream[0].hold && records_due.size() != 0)
						&& $urandom_range(0, 99) >= ((byte_stream[0].mode == IDLE_MIX_A) ? 27
						: (byte_stream[0].mode == IDLE_MIX_B) ? 46 : 0)) begin
					in_ch.valid <= 1'b1;
					in_ch.option_byte <= byte_stream[0].data;
					in_ch.last_byte <= byte_stream[0].last;
					rx_mode <= byte_stream[0].mode;
					void'(byte_stream.pop_front());
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// record monitor
	always @(posedge clk or negedge arst_n) begin
		opt_record_t got;
		opt_record_t want;
		if (!arst_n) begin
			rec_ch.ready <= 1'b0;
		end else begin
			if (rec_ch.valid && rec_ch.ready) begin
				got = '{rec_ch.record_kind, rec_ch.option_type, rec_ch.option_length,
					rec_ch.value_a, rec_ch.value_b, rec_ch.final_res, rec_ch.malformed};
				records_seen++;
				if (records_due.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected record, expected none, actual %p", $time, got);
				end else begin
					want = records_due.pop_front();
					check_field("record_kind", 32'(want.kind), 32'(got.kind));
					check_field("option_type", 32'(want.typ), 32'(got.typ));
					check_field("option_length", 32'(want.len), 32'(got.len));
					check_field("value_a", want.va, got.va);
					check_field("value_b", want.vb, got.vb);
					check_field("final_res", 32'(want.fin), 32'(got.fin));
					check_field("malformed", 32'(want.bad), 32'(got.bad));
				end
			end
			rec_ch.ready <= $urandom_range(0, 99) >= ((rx_mode == IDLE_MIX_A) ? 46
				: (rx_mode == IDLE_MIX_B) ? 27 : 0);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Verification failed");
			$finish;
		end
	end

endmodule
